/* rtl/spl_pkg.sv */
// ---------------------------------------------------------------------------
// spl_pkg
// Shared types, register indexes and constants of the sun pair lock
// qualifier.
// ---------------------------------------------------------------------------
package spl_pkg;

   // input field layout
   localparam int SAMPLE_FIELD_BITS = 12;
   localparam int SAMPLE_BITS_DEF   = 12;
   localparam int NUM_CHANNELS      = 4;
   localparam int REQ_DATA_BITS     = 48;
   localparam int RSP_DATA_BITS     = 8;

   // configuration register widths
   localparam int LIMIT_BITS = 8;
   localparam int TOL_BITS   = 7;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 8;

   // configuration register indexes
   localparam logic [CSR_ADDR_BITS-1:0] REG_ACQUIRE_LIMIT = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_LOSS_LIMIT    = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_TOLERANCE     = 2'd2;

   // reset values of the configuration registers
   localparam logic [LIMIT_BITS-1:0] ACQUIRE_LIMIT_RST = 8'd10;
   localparam logic [LIMIT_BITS-1:0] LOSS_LIMIT_RST    = 8'd5;
   localparam logic [TOL_BITS-1:0]   TOLERANCE_RST     = 7'd10;

   // percent denominator
   localparam int PCT_DEN = 100;

   // steer hint codes
   localparam logic [1:0] STEER_NONE  = 2'd0;
   localparam logic [1:0] STEER_TWO   = 2'd1;
   localparam logic [1:0] STEER_THREE = 2'd2;

   // limits shared by both lock machines
   typedef struct packed {
      logic [LIMIT_BITS-1:0] acquire_limit;
      logic [LIMIT_BITS-1:0] loss_limit;
   } lock_cfg_type;

endpackage

/* rtl/spl_pair_lane.sv */
// ---------------------------------------------------------------------------
// spl_pair_lane
// One channel-pair lane: adds two samples and registers the sum.
// ---------------------------------------------------------------------------
module spl_pair_lane #(
   parameter int SAMPLE_BITS = spl_pkg::SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   load,
   input  logic [SAMPLE_BITS-1:0] smp_a,
   input  logic [SAMPLE_BITS-1:0] smp_b,
   output logic [SAMPLE_BITS:0]   sum_ff
);
   import spl_pkg::*;

   logic [SAMPLE_BITS:0] sum_in;

   // pair sum, one bit wider than a sample
   assign sum_in = {1'b0, smp_a} + {1'b0, smp_b};

   always_ff @(posedge clock) begin
      if (load) begin
         sum_ff <= sum_in;
      end
   end

endmodule

/* rtl/spl_pair_merge.sv */
// ---------------------------------------------------------------------------
// spl_pair_merge
// Merges the four lane sums: the first strictly largest wins, and a hit
// means the channel two-three pair won.
// ---------------------------------------------------------------------------
module spl_pair_merge #(
   parameter int SAMPLE_BITS = spl_pkg::SAMPLE_BITS_DEF
) (
   input  logic [SAMPLE_BITS:0] sum_01,
   input  logic [SAMPLE_BITS:0] sum_12,
   input  logic [SAMPLE_BITS:0] sum_23,
   input  logic [SAMPLE_BITS:0] sum_31,
   output logic                 pair_hit
);
   import spl_pkg::*;

   logic [SAMPLE_BITS:0] best_early;

   // best of the first two lanes, earlier lane kept on a tie
   assign best_early = (sum_12 > sum_01) ? sum_12 : sum_01;

   // two-three must beat both earlier lanes and not be beaten by the last
   assign pair_hit = (sum_23 > best_early) && !(sum_31 > sum_23);

endmodule

/* rtl/spl_balance_lane.sv */
// ---------------------------------------------------------------------------
// spl_balance_lane
// Balance lane for channels two and three: registers the scaled
// difference and the tolerance product, then compares them.
// ---------------------------------------------------------------------------
module spl_balance_lane #(
   parameter int SAMPLE_BITS = spl_pkg::SAMPLE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         load,
   input  logic [SAMPLE_BITS-1:0]       smp_2,
   input  logic [SAMPLE_BITS-1:0]       smp_3,
   input  logic [spl_pkg::TOL_BITS-1:0] tolerance,
   output logic                         balanced,
   output logic                         two_brighter,
   output logic                         three_brighter
);
   import spl_pkg::*;

   localparam int PROD_BITS = SAMPLE_BITS + 1 + TOL_BITS;

   logic [SAMPLE_BITS:0]   sum_in;
   logic [SAMPLE_BITS-1:0] diff_in;
   logic [PROD_BITS-1:0]   prod_in;
   logic [PROD_BITS-1:0]   prod_ff;
   logic [PROD_BITS-1:0]   diff_scaled_in;
   logic [PROD_BITS-1:0]   diff_scaled_ff;
   logic                   gt_ff;
   logic                   lt_ff;

   // diff <= floor(sum * tol / 100) is the same as diff * 100 <= sum * tol
   assign sum_in         = {1'b0, smp_2} + {1'b0, smp_3};
   assign diff_in        = (smp_2 > smp_3) ? (smp_2 - smp_3) : (smp_3 - smp_2);
   assign prod_in        = PROD_BITS'(sum_in) * PROD_BITS'(tolerance);
   assign diff_scaled_in = PROD_BITS'(diff_in) * PROD_BITS'(PCT_DEN);

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff        <= prod_in;
         diff_scaled_ff <= diff_scaled_in;
         gt_ff          <= smp_2 > smp_3;
         lt_ff          <= smp_3 > smp_2;
      end
   end

   // compare in the second stage
   assign balanced       = diff_scaled_ff <= prod_ff;
   assign two_brighter   = gt_ff;
   assign three_brighter = lt_ff;

endmodule

/* rtl/spl_lock_fsm.sv */
// ---------------------------------------------------------------------------
// spl_lock_fsm
// Lock qualifier: counts consecutive hits to acquire a lock and
// consecutive misses to drop it.
// ---------------------------------------------------------------------------
module spl_lock_fsm (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  hit,
   input  spl_pkg::lock_cfg_type cfg,
   output logic                  lock_ff,
   output logic                  lock_in
);
   import spl_pkg::*;

   logic [LIMIT_BITS-1:0] hit_cnt_ff;
   logic [LIMIT_BITS-1:0] hit_cnt_in;
   logic [LIMIT_BITS-1:0] miss_cnt_ff;
   logic [LIMIT_BITS-1:0] miss_cnt_in;
   logic [LIMIT_BITS-1:0] miss_inc;

   assign miss_inc = miss_cnt_ff + 1'b1;

   // next state for one request
   always_comb begin
      lock_in     = lock_ff;
      hit_cnt_in  = hit_cnt_ff;
      miss_cnt_in = miss_cnt_ff;
      if (!lock_ff) begin
         if (hit) begin
            if (hit_cnt_ff < cfg.acquire_limit) begin
               hit_cnt_in = hit_cnt_ff + 1'b1;
            end else begin
               lock_in     = 1'b1;
               miss_cnt_in = '0;
            end
         end else begin
            hit_cnt_in = '0;
         end
      end else begin
         if (hit) begin
            miss_cnt_in = '0;
         end else if (miss_inc >= cfg.loss_limit) begin
            lock_in     = 1'b0;
            hit_cnt_in  = '0;
            miss_cnt_in = '0;
         end else begin
            miss_cnt_in = miss_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_ff     <= 1'b0;
         hit_cnt_ff  <= '0;
         miss_cnt_ff <= '0;
      end else if (step) begin
         lock_ff     <= lock_in;
         hit_cnt_ff  <= hit_cnt_in;
         miss_cnt_ff <= miss_cnt_in;
      end
   end

   // a lock is only gained on a hit
   a_lock_on_hit: assert property (@(posedge clock) disable iff (reset)
      $rose(lock_ff) |-> $past(step && hit))
      else $error("lock set without a hit");

   // misses are only counted while locked
   a_miss_idle: assert property (@(posedge clock) disable iff (reset)
      !lock_ff |-> miss_cnt_ff == '0)
      else $error("miss count nonzero while unlocked");

   // a lock is only dropped on a miss
   a_drop_on_miss: assert property (@(posedge clock) disable iff (reset)
      $fell(lock_ff) |-> $past(step && !hit))
      else $error("lock dropped without a miss");

endmodule

/* rtl/sun_pair_lock_qualifier_core.sv */
// ---------------------------------------------------------------------------
// sun_pair_lock_qualifier_core
// Four pair-sum lanes and a balance lane feed a merge stage and two lock
// machines that qualify the sun pair and its balance.
// Pipeline: the lane stage registers, then the result register.
// Throughput: one request per cycle unless the result side stalls; the
// lock machines update in the output stage and never hold back requests.
// Reset: synchronous; clears both lock machines, the pipeline valids and
// loads the default limits (acquire 10, loss 5, tolerance 10 percent).
// ---------------------------------------------------------------------------
module sun_pair_lock_qualifier_core #(
   parameter int SAMPLE_BITS = spl_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: sample_0 [11:0], sample_1 [23:12], sample_2 [35:24], sample_3 [47:36]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [spl_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // result: pair_now [0], balanced_now [1], pair_locked [2],
   // balance_locked [3], steer [5:4], zero [7:6]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [spl_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // configuration write port
   input  logic                              csr_we,
   input  logic [spl_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [spl_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import spl_pkg::*;

   // only the low bits of each field take part
   localparam int USE_BITS = (SAMPLE_BITS < SAMPLE_FIELD_BITS) ?
                             SAMPLE_BITS : SAMPLE_FIELD_BITS;

   logic [USE_BITS-1:0] smp [NUM_CHANNELS];

   logic [LIMIT_BITS-1:0] acquire_limit_ff;
   logic [LIMIT_BITS-1:0] loss_limit_ff;
   logic [TOL_BITS-1:0]   tolerance_ff;
   lock_cfg_type          lock_cfg;

   logic                  stage_valid_ff;
   logic                  rsp_valid_ff;
   logic                  advance;
   logic                  stage_load;
   logic                  step;

   logic [USE_BITS:0]     sum_01, sum_12, sum_23, sum_31;
   logic                  pair_hit;
   logic                  balanced;
   logic                  two_brighter;
   logic                  three_brighter;

   logic                  pair_lock_ff, pair_lock_in;
   logic                  bal_lock_ff, bal_lock_in;
   logic [1:0]            steer_in;
   logic [5:0]            rsp_bits_in;
   logic [5:0]            rsp_bits_ff;

   // unpack the samples
   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_unpack
      assign smp[i] = req_tdata[i*SAMPLE_FIELD_BITS +: USE_BITS];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         acquire_limit_ff <= ACQUIRE_LIMIT_RST;
         loss_limit_ff    <= LOSS_LIMIT_RST;
         tolerance_ff     <= TOLERANCE_RST;
      end else if (csr_we) begin
         case (csr_addr)
            REG_ACQUIRE_LIMIT: acquire_limit_ff <= csr_wdata[LIMIT_BITS-1:0];
            REG_LOSS_LIMIT:    loss_limit_ff    <= csr_wdata[LIMIT_BITS-1:0];
            REG_TOLERANCE:     tolerance_ff     <= csr_wdata[TOL_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign lock_cfg.acquire_limit = acquire_limit_ff;
   assign lock_cfg.loss_limit    = loss_limit_ff;

   // pipeline flow control
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !stage_valid_ff || advance;
   assign stage_load = req_tvalid && req_tready;
   assign step       = stage_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_tready) begin
            stage_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= stage_valid_ff;
         end
      end
   end

   // pair-sum lanes
   spl_pair_lane #(.SAMPLE_BITS(USE_BITS)) u_lane_01 (
      .clock(clock), .load(stage_load), .smp_a(smp[0]), .smp_b(smp[1]), .sum_ff(sum_01));
   spl_pair_lane #(.SAMPLE_BITS(USE_BITS)) u_lane_12 (
      .clock(clock), .load(stage_load), .smp_a(smp[1]), .smp_b(smp[2]), .sum_ff(sum_12));
   spl_pair_lane #(.SAMPLE_BITS(USE_BITS)) u_lane_23 (
      .clock(clock), .load(stage_load), .smp_a(smp[2]), .smp_b(smp[3]), .sum_ff(sum_23));
   spl_pair_lane #(.SAMPLE_BITS(USE_BITS)) u_lane_31 (
      .clock(clock), .load(stage_load), .smp_a(smp[3]), .smp_b(smp[1]), .sum_ff(sum_31));

   // balance lane
   spl_balance_lane #(.SAMPLE_BITS(USE_BITS)) u_balance (
      .clock         (clock),
      .load          (stage_load),
      .smp_2         (smp[2]),
      .smp_3         (smp[3]),
      .tolerance     (tolerance_ff),
      .balanced      (balanced),
      .two_brighter  (two_brighter),
      .three_brighter(three_brighter)
   );

   // merge stage
   spl_pair_merge #(.SAMPLE_BITS(USE_BITS)) u_merge (
      .sum_01  (sum_01),
      .sum_12  (sum_12),
      .sum_23  (sum_23),
      .sum_31  (sum_31),
      .pair_hit(pair_hit)
   );

   // pair lock machine
   spl_lock_fsm u_pair_lock (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .hit    (pair_hit),
      .cfg    (lock_cfg),
      .lock_ff(pair_lock_ff),
      .lock_in(pair_lock_in)
   );

   // balance lock machine sees the pair lock of the same request
   spl_lock_fsm u_bal_lock (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .hit    (balanced && pair_lock_in),
      .cfg    (lock_cfg),
      .lock_ff(bal_lock_ff),
      .lock_in(bal_lock_in)
   );

   // steer hint while balance is being sought
   always_comb begin
      steer_in = STEER_NONE;
      if (!bal_lock_ff && pair_lock_in && !balanced) begin
         if (two_brighter) begin
            steer_in = STEER_TWO;
         end else if (three_brighter) begin
            steer_in = STEER_THREE;
         end
      end
   end

   assign rsp_bits_in = {steer_in, bal_lock_in, pair_lock_in, balanced, pair_hit};

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_bits_ff <= rsp_bits_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_bits_ff};

   // steer only shows with the pair locked, balance unlocked and unbalanced
   a_steer_ctx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bits_ff[5:4] != STEER_NONE |->
         rsp_bits_ff[2] && !rsp_bits_ff[3] && !rsp_bits_ff[1])
      else $error("steer hint outside of balance seek");

   // a request is only refused while the lane stage holds one
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> stage_valid_ff && rsp_valid_ff)
      else $error("request refused with room in the pipeline");

   // an accepted request reaches the lane stage
   a_accept_stage: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> stage_valid_ff)
      else $error("accepted request lost");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks the sun pair lock qualifier against its own predictor of the raw
// pair and balance detects and both lock machines. Directed extremes come
// first, then random runs of hits, misses and ties under several limit
// settings, with bursty requests and a stalling result side.
// ---------------------------------------------------------------------------
module testbench;

   import spl_pkg::*;

   localparam int LATENCY      = 2;
   localparam int HOLD_CYCLES  = 250;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_LIMIT = 10;
   localparam int NUM_PHASES   = 8;

   // index past the last register, writes to it are ignored
   localparam logic [CSR_ADDR_BITS-1:0] REG_SPARE = 2'd3;

   // request fields, sample_0 in the lowest bits
   typedef struct packed {
      logic [SAMPLE_FIELD_BITS-1:0] sample_3;
      logic [SAMPLE_FIELD_BITS-1:0] sample_2;
      logic [SAMPLE_FIELD_BITS-1:0] sample_1;
      logic [SAMPLE_FIELD_BITS-1:0] sample_0;
   } sample_set_type;

   // result fields, pair_now in bit zero
   typedef struct packed {
      logic [1:0] zero;
      logic [1:0] steer;
      logic       balance_locked;
      logic       pair_locked;
      logic       balanced_now;
      logic       pair_now;
   } qual_result_type;

   typedef struct packed {
      logic                  locked;
      logic [LIMIT_BITS-1:0] hits;
      logic [LIMIT_BITS-1:0] misses;
   } lock_state_type;

   typedef enum int {RUN_BAL_HIT, RUN_SKEW_HIT, RUN_MISS, RUN_TIE, RUN_NOISE} run_kind_type;
   typedef enum int {READY_ALWAYS, READY_COIN, READY_EVERY_THIRD, READY_MOSTLY} stall_mode_type;

   // predictor of the qualifier and store of expected results
   class lock_scoreboard;
      logic [LIMIT_BITS-1:0] acquire_limit = ACQUIRE_LIMIT_RST;
      logic [LIMIT_BITS-1:0] loss_limit    = LOSS_LIMIT_RST;
      logic [TOL_BITS-1:0]   tolerance     = TOLERANCE_RST;
      lock_state_type        pair_st       = '0;
      lock_state_type        bal_st        = '0;
      qual_result_type       expected_q[$];
      int mismatches      = 0;
      int results_checked = 0;
      int pair_locks      = 0;
      int balance_locks   = 0;
      int steer_hints     = 0;

      function void set_register(logic [CSR_ADDR_BITS-1:0] idx,
                                 logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            REG_ACQUIRE_LIMIT: acquire_limit = value;
            REG_LOSS_LIMIT:    loss_limit = value;
            REG_TOLERANCE:     tolerance = value[TOL_BITS-1:0];
            default: ;
         endcase
      endfunction

      // locked machine: a hit clears misses, enough misses drop everything
      function lock_state_type hold_step(lock_state_type st, logic hit);
         if (hit) begin
            st.misses = '0;
         end else begin
            st.misses = st.misses + 8'd1;
            if (st.misses >= loss_limit) st = '0;
         end
         return st;
      endfunction

      // unlocked machine on a hit: count up, or lock
      function lock_state_type acquire_step(lock_state_type st);
         if (st.hits < acquire_limit) begin
            st.hits = st.hits + 8'd1;
         end else begin
            st.locked = 1'b1;
            st.misses = '0;
         end
         return st;
      endfunction

      function void note_request(sample_set_type s);
         int unsigned sums[4];
         int unsigned best;
         int unsigned pair_sum;
         int unsigned diff;
         int winner;
         logic hit;
         logic bal;
         logic [1:0] steer;
         logic was_pair;
         logic was_bal;
         qual_result_type r;
         sums[0] = s.sample_0 + s.sample_1;
         sums[1] = s.sample_1 + s.sample_2;
         sums[2] = s.sample_2 + s.sample_3;
         sums[3] = s.sample_3 + s.sample_1;
         best = sums[0];
         winner = 0;
         for (int i = 1; i < 4; i++) begin
            if (sums[i] > best) begin
               best = sums[i];
               winner = i;
            end
         end
         hit = (winner == 2);
         pair_sum = sums[2];
         diff = (s.sample_2 > s.sample_3) ? s.sample_2 - s.sample_3 : s.sample_3 - s.sample_2;
         bal = (diff <= (pair_sum * tolerance) / PCT_DEN);
         steer = STEER_NONE;
         was_pair = pair_st.locked;
         was_bal = bal_st.locked;

         // pair machine
         if (!pair_st.locked) begin
            if (hit) pair_st = acquire_step(pair_st);
            else pair_st.hits = '0;
         end else begin
            pair_st = hold_step(pair_st, hit);
         end

         // balance machine, sees this step's pair lock
         if (!bal_st.locked) begin
            if (pair_st.locked && bal) begin
               bal_st = acquire_step(bal_st);
            end else if (!pair_st.locked) begin
               bal_st.hits = '0;
            end else begin
               if (s.sample_2 > s.sample_3) steer = STEER_TWO;
               else if (s.sample_3 > s.sample_2) steer = STEER_THREE;
               bal_st.hits = '0;
            end
         end else begin
            bal_st = hold_step(bal_st, bal && pair_st.locked);
         end

         if (!was_pair && pair_st.locked) pair_locks++;
         if (!was_bal && bal_st.locked) balance_locks++;
         if (steer != STEER_NONE) steer_hints++;
         r.zero = '0;
         r.steer = steer;
         r.balance_locked = bal_st.locked;
         r.pair_locked = pair_st.locked;
         r.balanced_now = bal;
         r.pair_now = hit;
         expected_q.push_back(r);
      endfunction

      function void check_result(qual_result_type got);
         qual_result_type want;
         results_checked++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("[%0t] result with none expected: %h", $realtime, got);
            return;
         end
         want = expected_q.pop_front();
         if (got.pair_now !== want.pair_now || got.balanced_now !== want.balanced_now ||
             got.pair_locked !== want.pair_locked ||
             got.balance_locked !== want.balance_locked ||
             got.steer !== want.steer || got.zero !== want.zero) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("[%0t] result %0d: expected pair %b bal %b plock %b block %b ",
                        $realtime, results_checked,
                        want.pair_now, want.balanced_now, want.pair_locked,
                        want.balance_locked,
                        "steer %0d zero %0d, actual pair %b bal %b plock %b block %b ",
                        want.steer, want.zero,
                        got.pair_now, got.balanced_now, got.pair_locked,
                        got.balance_locked,
                        "steer %0d zero %0d", got.steer, got.zero);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_we     = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata  = '0;

   lock_scoreboard book = new;
   sample_set_type directed_q[$];
   run_kind_type   run_kind = RUN_NOISE;
   int             run_left = 0;
   int             cur_acquire = ACQUIRE_LIMIT_RST;
   int             cur_loss = LOSS_LIMIT_RST;
   int             cur_tol = TOLERANCE_RST;
   int             cycle_count = 0;
   int             requests_sent = 0;
   int             hold_requests = 0;

   sun_pair_lock_qualifier_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // clock
   initial begin
      forever #2 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, book.pending());
         $display("Some tests failed");
         $finish;
      end
   end

   // monitor both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) book.note_request(req_tdata);
         if (rsp_tvalid && rsp_tready) book.check_result(rsp_tdata);
      end
   end

   // result side stalls, with an occasional long hold-off
   initial begin : receiver
      int hold_left;
      int holds_seen;
      int mode_left;
      int beat;
      stall_mode_type mode;
      hold_left = 0;
      holds_seen = 0;
      mode_left = 0;
      beat = 0;
      mode = READY_ALWAYS;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_seen) begin
            hold_left = HOLD_CYCLES;
            holds_seen = hold_requests;
         end
         if (mode_left == 0) begin
            mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 150);
         end
         mode_left--;
         beat++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               READY_ALWAYS:      rsp_tready <= 1'b1;
               READY_COIN:        rsp_tready <= 1'($urandom_range(0, 1));
               READY_EVERY_THIRD: rsp_tready <= (beat % 3 == 0);
               default:           rsp_tready <= ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   function automatic sample_set_type pack_samples(int s0, int s1, int s2, int s3);
      sample_set_type s;
      s.sample_0 = 12'(s0);
      s.sample_1 = 12'(s1);
      s.sample_2 = 12'(s2);
      s.sample_3 = 12'(s3);
      return s;
   endfunction

   function automatic int pick_sample();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 4095;
         default: return $urandom_range(0, 4095);
      endcase
   endfunction

   // next request: directed list first, then runs shaped to reach the locks
   function automatic sample_set_type next_request();
      int unsigned pick;
      int b;
      int d;
      int dmax;
      int hi;
      int lo;
      int tot;
      int s0;
      int s1;
      int s2;
      int s3;
      if (directed_q.size() != 0) return directed_q.pop_front();
      if (run_left == 0) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) run_kind = RUN_BAL_HIT;
         else if (pick < 60) run_kind = RUN_SKEW_HIT;
         else if (pick < 80) run_kind = RUN_MISS;
         else if (pick < 86) run_kind = RUN_TIE;
         else run_kind = RUN_NOISE;
         case (run_kind)
            RUN_BAL_HIT, RUN_SKEW_HIT: run_left = $urandom_range(1, cur_acquire + cur_loss + 4);
            RUN_MISS: run_left = $urandom_range(1, cur_loss + 2);
            default: run_left = $urandom_range(1, 4);
         endcase
      end
      run_left--;
      case (run_kind)
         RUN_BAL_HIT, RUN_SKEW_HIT: begin
            b = $urandom_range(64, 4095);
            if (run_kind == RUN_BAL_HIT) begin
               dmax = b * cur_tol / PCT_DEN;
               if (dmax > b - 1) dmax = b - 1;
               d = $urandom_range(0, dmax);
            end else begin
               d = $urandom_range(1, b - 1);
            end
            hi = b;
            lo = b - d;
            if ($urandom_range(0, 1) == 1) begin
               s2 = hi;
               s3 = lo;
            end else begin
               s2 = lo;
               s3 = hi;
            end
            s1 = $urandom_range(0, lo - 1);
            tot = hi + lo - s1 - 1;
            s0 = $urandom_range(0, (tot > 4095) ? 4095 : tot);
         end
         RUN_MISS: begin
            s0 = $urandom_range(2048, 4095);
            s1 = pick_sample();
            s2 = pick_sample();
            s3 = pick_sample();
         end
         RUN_TIE: begin
            s2 = $urandom_range(0, 4095);
            s3 = $urandom_range(0, 4095);
            if ($urandom_range(0, 1) == 1) begin
               // first pair sum equals the (2,3) sum
               tot = s2 + s3;
               s1 = $urandom_range((tot > 4095) ? tot - 4095 : 0, (tot > 4095) ? 4095 : tot);
               s0 = tot - s1;
            end else begin
               // (1,2) sum equals the (2,3) sum
               s1 = s3;
               s0 = 0;
            end
         end
         default: begin
            s0 = pick_sample();
            s1 = pick_sample();
            s2 = pick_sample();
            s3 = pick_sample();
         end
      endcase
      return pack_samples(s0, s1, s2, s3);
   endfunction

   task automatic write_register(input logic [CSR_ADDR_BITS-1:0] idx,
                                 input logic [CSR_DATA_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      book.set_register(idx, value);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_limits(input int acq, input int loss, input int tol);
      write_register(REG_ACQUIRE_LIMIT, 8'(acq));
      write_register(REG_LOSS_LIMIT, 8'(loss));
      write_register(REG_TOLERANCE, 8'(tol));
      cur_acquire = acq & 8'hFF;
      cur_loss = loss & 8'hFF;
      cur_tol = tol & 8'h7F;
   endtask

   // bursty request sender
   task automatic send_requests(input int count);
      int burst;
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
      for (int n = 0; n < count; n++) begin
         if (burst == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) :
                                                  $urandom_range(1, 24);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= next_request();
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         burst--;
         requests_sent++;
      end
      req_tvalid <= 1'b0;
   endtask

   // wait for an edge first so the monitor has noted the last accepted request
   task automatic wait_drained();
      @(posedge clock);
      while (book.pending() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // main sequence
   initial begin : main
      int items;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes under reset limits: zeros, full scale, ties, balanced and skewed hits
      directed_q.push_back(pack_samples(0, 0, 0, 0));
      directed_q.push_back(pack_samples(4095, 4095, 4095, 4095));
      directed_q.push_back(pack_samples(4095, 0, 4095, 0));
      directed_q.push_back(pack_samples(0, 0, 4095, 4095));
      directed_q.push_back(pack_samples(0, 0, 4095, 3686));
      directed_q.push_back(pack_samples(0, 0, 100, 4095));
      send_requests(directed_q.size());
      wait_drained();

      // zero limits and zero tolerance: immediate locks, first miss drops
      set_limits(0, 0, 0);
      write_register(REG_SPARE, 8'hFF);
      directed_q.push_back(pack_samples(0, 0, 2000, 2000));
      directed_q.push_back(pack_samples(0, 0, 2001, 2000));
      directed_q.push_back(pack_samples(0, 0, 3000, 10));
      directed_q.push_back(pack_samples(0, 0, 10, 3000));
      directed_q.push_back(pack_samples(4095, 4095, 0, 0));
      directed_q.push_back(pack_samples(0, 0, 4095, 4095));
      directed_q.push_back(pack_samples(1000, 0, 500, 500));
      directed_q.push_back(pack_samples(0, 4095, 4095, 4095));
      send_requests(directed_q.size());
      wait_drained();

      // tolerance written with its top bit set lands above one hundred
      set_limits(1, 2, 8'hFF);
      directed_q.push_back(pack_samples(0, 0, 4095, 500));
      directed_q.push_back(pack_samples(0, 0, 4095, 500));
      directed_q.push_back(pack_samples(0, 0, 0, 4095));
      directed_q.push_back(pack_samples(4095, 4095, 1, 0));
      directed_q.push_back(pack_samples(4095, 4095, 1, 0));
      send_requests(directed_q.size());
      wait_drained();

      // random phases, lock state carries over into each new setting
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin set_limits(10, 5, 10);   items = 180; end
            1: begin set_limits(0, 0, 0);     items = 180; end
            2: begin set_limits(255, 255, 100); items = 420; end
            3: begin set_limits(1, 1, 8'hFF); items = 160; end
            4: begin set_limits(3, 2, 50);    items = 180; end
            default: begin
               set_limits($urandom_range(0, 20), $urandom_range(0, 10), $urandom_range(0, 100));
               items = 170;
            end
         endcase
         if (p == 1 || p == 4) hold_requests++;
         send_requests(items);
         wait_drained();
      end

      $display("covered %0d requests, %0d results over eleven limit settings",
               requests_sent, book.results_checked);
      $display("saw %0d pair locks, %0d balance locks, %0d steer hints, %0d mismatches",
               book.pair_locks, book.balance_locks, book.steer_hints, book.mismatches);
      if (book.mismatches == 0 && book.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
